// ===== sv/ksc_pkg.sv =====
// Package for the keyed store CAM: sizes, operation codes, clamp limits
// and the command and status structs between controller and datapath.
// No dependencies.
package ksc_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic signed [31:0] VAL_MAX = 32'sd1000000;
  localparam logic signed [31:0] VAL_MIN = -32'sd1000000;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } ksc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ksc_stat_t;

endpackage

// ===== sv/ksc_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on ksc_pkg for the count width.
interface ksc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [63:0]        lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, kind, lookup_key, write_value, input ready);
  modport sink (input valid, kind, lookup_key, write_value, output ready);
endinterface

interface ksc_rsp_if;
  import ksc_pkg::*;
  logic               valid;
  logic               ready;
  logic               success;
  logic signed [31:0] read_value;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, success, read_value, entry_count, input ready);
  modport sink (input valid, success, read_value, entry_count, output ready);
endinterface

// ===== sv/ksc_ctrl.sv =====
// Controller for the keyed store CAM: accept, scan, drain, commit sequence.
// Depends on ksc_pkg.
module ksc_ctrl import ksc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ksc_stat_t stat,
  output ksc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== sv/ksc_datapath.sv =====
// Datapath for the keyed store CAM: slot memories, valid bits, scan
// compare, update logic and the output register. Depends on ksc_pkg.
module ksc_datapath import ksc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ksc_cmd_t           cmd,
  output ksc_stat_t          stat,
  input  logic [1:0]         kind,
  input  logic [63:0]        lookup_key,
  input  logic signed [31:0] write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               success,
  output logic signed [31:0] read_value,
  output logic [CNT_W-1:0]   entry_count
);

  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic signed [31:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0] slot_valid;
  logic [CNT_W-1:0]   count;

  logic [1:0]         kind_r;
  logic [KEY_W-1:0]   key_r;
  logic signed [31:0] val_r;

  logic [IDX_W-1:0]   idx;
  logic               issued;
  logic [KEY_W-1:0]   rkey;
  logic signed [31:0] rval;
  logic               rvld;
  logic [IDX_W-1:0]   ridx;

  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic signed [31:0] hit_val;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic               ok;
  logic signed [31:0] rd;
  logic               wr_key;
  logic               wr_val;
  logic [IDX_W-1:0]   waddr;
  logic signed [31:0] wdata;
  logic               set_valid;
  logic               clr_valid;
  logic [CNT_W-1:0]   count_next;
  logic signed [31:0] clamped;

  assign stat.scan_last = (idx == IDX_W'(ENTRIES - 1));
  assign stat.out_free  = !out_valid || out_ready;

  assign clamped = (val_r < VAL_MIN) ? VAL_MIN : ((val_r > VAL_MAX) ? VAL_MAX : val_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      key_r  <= lookup_key[KEY_W-1:0];
      val_r  <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
    end else begin
      issued <= cmd.scan_step;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rkey <= key_mem[idx];
      rval <= val_mem[idx];
      rvld <= slot_valid[idx];
      ridx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (issued) begin
      if (rvld && (rkey == key_r) && !hit) begin
        hit     <= 1'b1;
        hit_idx <= ridx;
        hit_val <= rval;
      end
      if (!rvld && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= ridx;
      end
    end
  end

  always_comb begin
    ok         = 1'b0;
    rd         = '0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    waddr      = hit_idx;
    wdata      = val_r;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    count_next = count;
    case (kind_r)
      KIND_SET: begin
        if (hit) begin
          wr_val = 1'b1;
          ok     = 1'b1;
        end else if (free_found) begin
          waddr      = free_idx;
          wr_key     = 1'b1;
          wr_val     = 1'b1;
          wdata      = clamped;
          set_valid  = 1'b1;
          count_next = CNT_W'(count + 1'b1);
          ok         = 1'b1;
        end
      end
      KIND_GET: begin
        if (hit) begin
          ok = 1'b1;
          rd = hit_val;
        end
      end
      KIND_DEL: begin
        if (hit) begin
          clr_valid = 1'b1;
          if (count != '0) count_next = CNT_W'(count - 1'b1);
          ok = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_key) key_mem[waddr] <= key_r;
    if (cmd.commit && wr_val) val_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (cmd.commit) begin
      if (set_valid) slot_valid[waddr] <= 1'b1;
      if (clr_valid) slot_valid[waddr] <= 1'b0;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.commit) begin
      success     <= ok;
      read_value  <= rd;
      entry_count <= count_next;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(slot_valid)))
    else $error("live count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("live count above table size");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && (entry_count == count))
    else $error("committed result not presented with current count");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free && !cmd.load && !cmd.scan_step)
    else $error("commit overlaps scan or busy output");

endmodule

// ===== sv/keyed_store_cam.sv =====
// Top level of the keyed store CAM: associative key/value table.
// Depends on ksc_pkg, ksc_if, ksc_ctrl and ksc_datapath.
//
//   channel  dir  fields
//   req      in   kind[1:0], lookup_key[63:0], write_value[31:0] signed
//   rsp      out  success, read_value[31:0] signed, entry_count[4:0]
//
// An item passes from accept to result through one accept step, one slot
// memory read per entry, one compare drain step and one commit step. The
// scan reads one slot a cycle from the key/value memories. Reset clears all
// valid bits and the count at once; no clear pass.
// A result waiting on rsp does not stop the next accept, only its commit.
module keyed_store_cam import ksc_pkg::*; (
  input logic     clk,
  input logic     rst,
  ksc_req_if.sink   req,
  ksc_rsp_if.source rsp
);

  ksc_cmd_t  cmd;
  ksc_stat_t stat;

  ksc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (req.kind),
    .lookup_key  (req.lookup_key),
    .write_value (req.write_value),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .success     (rsp.success),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count)
  );

endmodule
